>>> rtl/core/mctn_pkg.sv
// ----------------------------------------------------------------------------
// mctn_pkg: shared types and constants for the tone and noise mixer
// item layouts, command bundle for the channel cells and the sine table builder
// ----------------------------------------------------------------------------
package mctn_pkg;

  localparam int NUM_CHANNELS_DEF   = 8;
  localparam int SAMPLE_RATE_DEF    = 44100;
  localparam int SINE_DEPTH_DEF     = 256;
  localparam int PHASE_BITS_DEF     = 32;

  localparam int SUM_W              = 24;
  localparam int REMAIN_W           = 24;
  localparam logic [15:0] NOISE_SEED = 16'h1234;
  localparam logic [15:0] NOISE_TAPS = 16'hB400;
  localparam int MS_PER_SEC         = 1000;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  // floor(z / 1000) as (z * MS_RECIP) >> MS_RECIP_SH, exact for z below 2^MS_FRAC_W
  localparam int MS_FRAC_W   = 26;
  localparam int MS_RECIP_W  = 27;
  localparam int MS_RECIP_SH = 36;
  localparam logic [MS_RECIP_W-1:0] MS_RECIP =
    MS_RECIP_W'((64'd1 << MS_RECIP_SH) / 64'(MS_PER_SEC) + 64'd1);

  localparam logic [1:0] OP_TICK = 2'd0;
  localparam logic [1:0] OP_PLAY = 2'd1;
  localparam logic [1:0] OP_STOP = 2'd2;

  localparam logic [2:0] SHAPE_SQUARE   = 3'd0;
  localparam logic [2:0] SHAPE_TRIANGLE = 3'd1;
  localparam logic [2:0] SHAPE_SAW      = 3'd2;
  localparam logic [2:0] SHAPE_SINE     = 3'd3;
  localparam logic [2:0] SHAPE_NOISE    = 3'd4;

  typedef struct packed {
    logic [1:0]  op;
    logic [2:0]  channel;
    logic [31:0] tone_step;
    logic [15:0] tone_ms;
    logic [2:0]  wave_shape;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] pcm_left;
    logic signed [15:0] pcm_right;
  } out_item_t;

  // broadcast to every cell
  typedef struct packed {
    logic                play;
    logic                stop;
    logic [2:0]          channel;
    logic [2:0]          shape;
    logic [31:0]         step;
    logic [REMAIN_W-1:0] remaining;
  } cell_cmd_t;

  // quarter-wave sine magnitude, Q15, from a Q30 angle, evaluated at elaboration only
  function automatic logic [15:0] sine_entry(input longint unsigned x);
    longint unsigned x2, term, sum, q15;
    x2   = (x * x) >> 30;
    term = x;
    sum  = x;
    term = ((term * x2) >> 30) / 64'd6;
    sum  = sum - term;
    term = ((term * x2) >> 30) / 64'd20;
    sum  = sum + term;
    term = ((term * x2) >> 30) / 64'd42;
    sum  = sum - term;
    term = ((term * x2) >> 30) / 64'd72;
    sum  = sum + term;
    term = ((term * x2) >> 30) / 64'd110;
    sum  = sum - term;
    term = ((term * x2) >> 30) / 64'd156;
    sum  = sum + term;
    q15 = (sum + 64'd16384) >> 15;
    if (q15 > 64'd32768) q15 = 64'd32768;
    return q15[15:0];
  endfunction

endpackage

>>> rtl/core/mctn_cell.sv
// ----------------------------------------------------------------------------
// mctn_cell: one synthesizer channel
// holds phase, step, shape, countdown and noise register; adds its quarter
// scaled value to the running sum handed along the chain
// ----------------------------------------------------------------------------
module mctn_cell #(
  parameter int IDX        = 0,
  parameter int PHASE_W    = 32,
  parameter int SINE_DEPTH = 256
) (
  input  logic                               clk,
  input  logic                               rst,
  input  mctn_pkg::cell_cmd_t                cmd,
  input  logic                               go_in,
  input  logic signed [mctn_pkg::SUM_W-1:0]  sum_in,
  output logic                               go_out,
  output logic signed [mctn_pkg::SUM_W-1:0]  sum_out
);
  import mctn_pkg::*;

  localparam int IW = $clog2(SINE_DEPTH + 1);

  logic                active;
  logic [2:0]          shape;
  logic [PHASE_W-1:0]  step;
  logic [PHASE_W-1:0]  phase;
  logic [REMAIN_W-1:0] remaining;
  logic [15:0]         noise;

  logic [15:0]         sine_tab [0:SINE_DEPTH];
  logic [15:0]         p;
  logic [14+IW-1:0]    idx_prod;
  logic [IW-1:0]       idx;
  logic [IW-1:0]       mirror;
  logic [15:0]         mag;
  logic [15:0]         noise_next;
  logic signed [17:0]  val;
  logic signed [SUM_W-1:0] contrib;
  logic                sel;

  for (genvar k = 0; k <= SINE_DEPTH; k++) begin : g_tab
    // table angle k * (pi/2) / depth in q30
    localparam longint unsigned ANGLE = (64'(k) * HALF_PI_Q30) / 64'(SINE_DEPTH);
    assign sine_tab[k] = sine_entry(ANGLE);
  end

  assign sel = cmd.play && (cmd.channel == 3'(IDX)) && (IDX < 8);
  assign p   = phase[PHASE_W-1 -: 16];

  always_comb begin
    idx_prod   = (14+IW)'(p[13:0]) * (14+IW)'(SINE_DEPTH);
    idx        = idx_prod[14+IW-1:14];
    mirror     = IW'(SINE_DEPTH) - idx;
    mag        = p[14] ? sine_tab[mirror] : sine_tab[idx];
    noise_next = noise[0] ? ((noise >> 1) ^ NOISE_TAPS) : (noise >> 1);
    case (shape)
      SHAPE_SQUARE:   val = p[15] ? -18'sd32768 : 18'sd32768;
      SHAPE_TRIANGLE: begin
        if (p < 16'd16384) val = 18'sd2 * $signed({2'b00, p});
        else if (p < 16'd49152) val = 18'sd65536 - 18'sd2 * $signed({2'b00, p});
        else val = 18'sd2 * $signed({2'b00, p}) - 18'sd131072;
      end
      SHAPE_SAW:      val = $signed({2'b00, p}) - 18'sd32768;
      SHAPE_SINE:     val = p[15] ? -$signed({2'b00, mag}) : $signed({2'b00, mag});
      default:        val = $signed({2'b00, noise_next}) - 18'sd32768;
    endcase
    contrib = active ? SUM_W'(val >>> 2) : '0;
  end

  always_ff @(posedge clk) begin
    go_out  <= rst ? 1'b0 : go_in;
    sum_out <= sum_in + contrib;
    if (rst) begin
      active    <= 1'b0;
      shape     <= SHAPE_SQUARE;
      step      <= '0;
      phase     <= '0;
      remaining <= '0;
      noise     <= NOISE_SEED;
    end else if (cmd.stop) begin
      active    <= 1'b0;
      phase     <= '0;
      remaining <= '0;
      noise     <= NOISE_SEED;
    end else if (sel) begin
      active    <= 1'b1;
      shape     <= (cmd.shape > SHAPE_NOISE) ? SHAPE_NOISE : cmd.shape;
      step      <= cmd.step[PHASE_W-1:0];
      phase     <= '0;
      remaining <= cmd.remaining;
    end else if (go_in && active) begin
      phase <= phase + step;
      if (shape != SHAPE_SQUARE && shape != SHAPE_TRIANGLE &&
          shape != SHAPE_SAW && shape != SHAPE_SINE) begin
        noise <= noise_next;
      end
      if (remaining != '0) begin
        remaining <= remaining - 1'b1;
        if (remaining == REMAIN_W'(1)) active <= 1'b0;
      end
    end
  end

endmodule

>>> rtl/core/multichannel_tone_noise_mixer.sv
// ----------------------------------------------------------------------------
// multichannel_tone_noise_mixer: multichannel tone and noise synthesizer
// a row of channel cells passes a running mix sum along; the top level
// sequences items, converts durations and formats the pcm result
// ----------------------------------------------------------------------------
// usage:
//  in channel (in_valid/in_ready/in_item) carries three kinds of item:
//   tick makes one stereo sample, play arms one channel, stop silences all
//  out channel (out_valid/out_ready/out_item) carries one sample per tick,
//   with the same value on left and right
//  item handling:
//   tick  - the launch flag, each cell's register in turn, the sum capture
//           and the formatted output register lie between the accept and
//           out_valid; the next item is taken once out_valid is loaded
//   play  - ms * rate / 1000 split into whole and reciprocal parts
//   stop  - a registered stop command to all cells
//  an item is taken whenever the sequencer is idle, even while a sample
//  still waits on the output register; a stalled receiver only holds the
//  next tick at its final step until the output register frees up
//  reset: all channels silent, phases zero, noise registers at their seed,
//  output empty
// ----------------------------------------------------------------------------
module multichannel_tone_noise_mixer #(
  parameter int NUM_CHANNELS     = mctn_pkg::NUM_CHANNELS_DEF,
  parameter int SAMPLE_RATE_HZ   = mctn_pkg::SAMPLE_RATE_DEF,
  parameter int SINE_TABLE_DEPTH = mctn_pkg::SINE_DEPTH_DEF,
  parameter int PHASE_BITS       = mctn_pkg::PHASE_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  mctn_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output mctn_pkg::out_item_t out_item
);
  import mctn_pkg::*;

  // rate split as whole samples per ms plus a remainder over 1000
  localparam int RATE_KHZ  = SAMPLE_RATE_HZ / MS_PER_SEC;
  localparam int RATE_FRAC = SAMPLE_RATE_HZ % MS_PER_SEC;
  localparam int RP_W      = MS_FRAC_W + MS_RECIP_W;

  typedef enum logic [1:0] {S_IDLE, S_DIV, S_TICK, S_DONE} state_t;

  state_t               state;
  cell_cmd_t            cmd;
  logic                 go0;
  in_item_t             held;
  logic [REMAIN_W-1:0]  cnt_whole;  // ms * whole samples per ms
  logic [MS_FRAC_W-1:0] frac_part;  // ms * leftover rate, still over 1000
  logic [RP_W-1:0]      recip_prod;
  logic signed [SUM_W-1:0] sum_hold;

  logic                 chain_go  [0:NUM_CHANNELS];
  logic signed [SUM_W-1:0] chain_sum [0:NUM_CHANNELS];

  logic signed [17:0]   sat;
  logic [16:0]          mag;
  logic [31:0]          scaled;
  logic signed [15:0]   pcm;

  assign chain_go[0]  = go0;
  assign chain_sum[0] = '0;

  // one cell per channel, sum flows from cell 0 upward
  for (genvar i = 0; i < NUM_CHANNELS; i++) begin : g_cell
    mctn_cell #(
      .IDX(i), .PHASE_W(PHASE_BITS), .SINE_DEPTH(SINE_TABLE_DEPTH)
    ) u_cell (
      .clk(clk), .rst(rst), .cmd(cmd),
      .go_in(chain_go[i]), .sum_in(chain_sum[i]),
      .go_out(chain_go[i+1]), .sum_out(chain_sum[i+1])
    );
  end

  assign in_ready = (state == S_IDLE);

  // divide by 1000 through the reciprocal multiply
  assign recip_prod = RP_W'(frac_part) * RP_W'(MS_RECIP);

  // saturate to +-1.0, scale by 32767/32768 truncating toward zero
  always_comb begin
    if (sum_hold > SUM_W'(32768)) sat = 18'sd32768;
    else if (sum_hold < -SUM_W'(32768)) sat = -18'sd32768;
    else sat = 18'(sum_hold);
    mag    = sat[17] ? 17'(-sat) : 17'(sat);
    scaled = 32'(mag) * 32'd32767;
    pcm    = sat[17] ? -$signed(scaled[30:15]) : $signed(scaled[30:15]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cmd       <= '0;
      go0       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      cmd.play <= 1'b0;
      cmd.stop <= 1'b0;
      go0      <= 1'b0;
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            held <= in_item;
            case (in_item.op)
              OP_TICK: begin
                go0   <= 1'b1;
                state <= S_TICK;
              end
              OP_PLAY: begin
                cnt_whole <= REMAIN_W'(in_item.tone_ms) * REMAIN_W'(RATE_KHZ);
                frac_part <= MS_FRAC_W'(in_item.tone_ms) * MS_FRAC_W'(RATE_FRAC);
                state     <= S_DIV;
              end
              OP_STOP: cmd.stop <= 1'b1;
              default: ;
            endcase
          end
        end
        S_DIV: begin
          cmd.play      <= 1'b1;
          cmd.channel   <= held.channel;
          cmd.shape     <= held.wave_shape;
          cmd.step      <= held.tone_step;
          cmd.remaining <= cnt_whole + REMAIN_W'(recip_prod[RP_W-1:MS_RECIP_SH]);
          state         <= S_IDLE;
        end
        S_TICK: begin
          if (chain_go[NUM_CHANNELS]) begin
            sum_hold <= chain_sum[NUM_CHANNELS];
            state    <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid          <= 1'b1;
            out_item.pcm_left  <= pcm;
            out_item.pcm_right <= pcm;
            state              <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
